/* rtl/core/mcfwa_pkg.sv */
`timescale 1ns / 1ps
// mcfwa_pkg: types, register codes, unit op codes and constants shared by the
// frame window aligner modules. No dependencies.
package mcfwa_pkg;

	localparam int DEF_NUM_CAMERAS = 4;
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int TS_BITS         = 48;
	localparam int NUM_OFFSETS     = 4;
	localparam int CFG_AW          = 5;

	typedef logic signed [TS_BITS-1:0] ts_t;

	localparam ts_t TS_MAX = {1'b0, {(TS_BITS-1){1'b1}}};
	localparam ts_t TS_MIN = {1'b1, {(TS_BITS-1){1'b0}}};

	// register index = paddr[4:2]
	localparam logic [2:0] REG_WIN_LEN        = 3'd0;
	localparam logic [2:0] REG_CAMERAS_IN_USE = 3'd1;
	localparam logic [2:0] REG_OFFSET_CAM0    = 3'd2;
	localparam logic [2:0] REG_OFFSET_CAM1    = 3'd3;
	localparam logic [2:0] REG_OFFSET_CAM2    = 3'd4;
	localparam logic [2:0] REG_OFFSET_CAM3    = 3'd5;

	// shared arithmetic unit ops
	localparam logic [1:0] OP_SUB_SAT = 2'd0;
	localparam logic [1:0] OP_ADD_SAT = 2'd1;
	localparam logic [1:0] OP_LT      = 2'd2;

	typedef struct packed {
		logic [1:0]  in_camera;
		ts_t         in_timestamp;
		logic [15:0] in_frame_id;
	} in_req_t;

	typedef struct packed {
		logic [1:0]  out_camera;
		logic        out_valid;
		logic [15:0] out_frame_id;
		ts_t         out_timestamp;
		logic [31:0] out_sequence;
		logic        out_last;
	} out_rsp_t;

	typedef struct packed {
		ts_t         ts;
		logic [15:0] id;
	} tag_t;

	typedef struct packed {
		logic [31:0]                  win_len;
		logic [2:0]                   cameras_in_use;
		logic [NUM_OFFSETS-1:0][31:0] offset;
	} cfg_t;

	typedef struct packed {
		logic [1:0] op;
		ts_t        a;
		ts_t        b;
	} alu_req_t;

	typedef struct packed {
		ts_t  res;
		logic lt;
	} alu_rsp_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic rd;
	} q_ctrl_t;

endpackage

/* rtl/core/mcfwa_alu.sv */
`timescale 1ns / 1ps
// mcfwa_alu: shared saturating add/subtract and signed compare on timestamps.
// Depends on mcfwa_pkg.
module mcfwa_alu (
	input  mcfwa_pkg::alu_req_t req,
	output mcfwa_pkg::alu_rsp_t rsp
);
	import mcfwa_pkg::*;

	logic signed [TS_BITS+1:0] ax;
	logic signed [TS_BITS+1:0] bx;
	logic signed [TS_BITS+1:0] s;
	logic                      ovf;

	always_comb begin
		ax = (TS_BITS+2)'($signed(req.a));
		bx = (TS_BITS+2)'($signed(req.b));
		unique case (req.op) inside
			OP_ADD_SAT:        s = ax + bx;
			OP_SUB_SAT, OP_LT: s = ax - bx;
			default:           s = ax - bx;
		endcase
		// top three bits agree when the result fits the timestamp range
		ovf = (s[TS_BITS+1:TS_BITS-1] != '0) && (s[TS_BITS+1:TS_BITS-1] != '1);
		rsp.res = ovf ? (s[TS_BITS+1] ? TS_MIN : TS_MAX) : s[TS_BITS-1:0];
		rsp.lt  = s[TS_BITS+1];
	end

endmodule

/* rtl/core/mcfwa_queue.sv */
`timescale 1ns / 1ps
// mcfwa_queue: per-camera circular tag FIFOs in one shared memory, with head
// pointers and fill counts. Depends on mcfwa_pkg.
module mcfwa_queue #(
	parameter int NUM_CAMERAS = mcfwa_pkg::DEF_NUM_CAMERAS,
	parameter int QUEUE_DEPTH = mcfwa_pkg::DEF_QUEUE_DEPTH,
	localparam int CIDX_W = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mcfwa_pkg::q_ctrl_t   ctrl,
	input  logic [CIDX_W-1:0]    sel,
	input  mcfwa_pkg::tag_t      wdata,
	output logic                 empty,
	output mcfwa_pkg::tag_t      rdata
);
	import mcfwa_pkg::*;

	localparam int HW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = $clog2(2 * QUEUE_DEPTH);
	localparam int AW = $clog2(NUM_CAMERAS * QUEUE_DEPTH);
	localparam logic [AW-1:0] DEPTH_A = AW'(QUEUE_DEPTH);

	logic [HW-1:0] head_q [NUM_CAMERAS];
	logic [CW-1:0] cnt_q  [NUM_CAMERAS];
	tag_t          mem_q  [NUM_CAMERAS * QUEUE_DEPTH];
	tag_t          rdata_q;

	logic [HW-1:0] hsel;
	logic [CW-1:0] csel;
	logic [HW-1:0] hnext;
	logic          full;
	logic [SW-1:0] sum;
	logic [HW-1:0] slot;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	always_comb begin
		hsel  = head_q[sel];
		csel  = cnt_q[sel];
		full  = (csel == CW'(QUEUE_DEPTH));
		hnext = (hsel == HW'(QUEUE_DEPTH - 1)) ? '0 : hsel + 1'b1;
		sum   = SW'(hsel) + SW'(csel);
		// full push overwrites the oldest slot, which is the head itself
		if (full)
			slot = hsel;
		else if (sum >= SW'(QUEUE_DEPTH))
			slot = HW'(sum - SW'(QUEUE_DEPTH));
		else
			slot = HW'(sum);
		waddr = AW'(sel) * DEPTH_A + AW'(slot);
		raddr = AW'(sel) * DEPTH_A + AW'(hsel);
	end

	assign empty = (csel == '0);
	assign rdata = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CAMERAS; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else if (ctrl.push) begin
			if (full)
				head_q[sel] <= hnext;
			else
				cnt_q[sel] <= csel + 1'b1;
		end else if (ctrl.pop) begin
			head_q[sel] <= hnext;
			cnt_q[sel]  <= csel - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push)
			mem_q[waddr] <= wdata;
		if (ctrl.rd)
			rdata_q <= mem_q[raddr];
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		csel <= CW'(QUEUE_DEPTH))
		else $error("queue fill count above depth");
	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.push && ctrl.pop))
		else $error("push and pop in one cycle");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.pop || ctrl.rd) |-> !empty)
		else $error("read or pop of an empty queue");
	a_pop_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> $past(ctrl.rd))
		else $error("pop without a head read the cycle before");
`endif

endmodule

/* rtl/core/mcfwa_ctrl.sv */
`timescale 1ns / 1ps
// mcfwa_ctrl: sequencer for the aligner. Drives the shared unit and the
// queues, holds window state, kept tags and the output register.
// Depends on mcfwa_pkg.
module mcfwa_ctrl #(
	parameter int NUM_CAMERAS = mcfwa_pkg::DEF_NUM_CAMERAS,
	localparam int CIDX_W = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mcfwa_pkg::cfg_t      cfg,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mcfwa_pkg::in_req_t   in_req,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mcfwa_pkg::out_rsp_t  out_rsp,
	output mcfwa_pkg::alu_req_t  alu_req,
	input  mcfwa_pkg::alu_rsp_t  alu_rsp,
	output mcfwa_pkg::q_ctrl_t   q_ctrl,
	output logic [CIDX_W-1:0]    q_sel,
	output mcfwa_pkg::tag_t      q_wdata,
	input  logic                 q_empty,
	input  mcfwa_pkg::tag_t      q_rdata
);
	import mcfwa_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_OFFS = 4'd1;
	localparam logic [3:0] S_PUSH = 4'd2;
	localparam logic [3:0] S_CMP  = 4'd3;
	localparam logic [3:0] S_WST  = 4'd4;
	localparam logic [3:0] S_RD   = 4'd5;
	localparam logic [3:0] S_CHK  = 4'd6;
	localparam logic [3:0] S_EMIT = 4'd7;

	logic [3:0]             state_q;
	logic [1:0]             cam_q;
	ts_t                    ts_q;
	logic [15:0]            id_q;
	ts_t                    limit_q;
	ts_t                    ws_q;
	logic [31:0]            seq_q;
	logic [CIDX_W-1:0]      c_q;
	logic [NUM_CAMERAS-1:0] have_q;
	tag_t                   kept_q [NUM_CAMERAS];
	out_rsp_t               orsp_q;
	logic                   ovld_q;

	logic [3:0] cams4;
	logic [3:0] arity;
	logic       cam_ok;
	logic       c_last;
	logic       load;
	tag_t       kept_c;

	always_comb begin
		cams4  = {1'b0, cfg.cameras_in_use};
		arity  = (cams4 > 4'(NUM_CAMERAS)) ? 4'(NUM_CAMERAS) : cams4;
		cam_ok = ({2'b00, in_req.in_camera} < arity);
		c_last = ((4'(c_q) + 4'd1) == arity);
		load   = (state_q == S_EMIT) && (!ovld_q || !out_stall);
		kept_c = kept_q[c_q];
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = ovld_q;
	assign out_rsp   = orsp_q;

	// shared unit operand select
	always_comb begin
		alu_req.op = OP_LT;
		alu_req.a  = ts_q;
		alu_req.b  = ws_q;
		unique case (state_q)
			S_OFFS: begin
				alu_req.op = OP_SUB_SAT;
				alu_req.a  = ts_q;
				alu_req.b  = TS_BITS'($signed(cfg.offset[cam_q]));
			end
			S_PUSH: begin
				alu_req.op = OP_ADD_SAT;
				alu_req.a  = ws_q;
				alu_req.b  = TS_BITS'(cfg.win_len);
			end
			S_CMP: begin
				alu_req.op = OP_LT;
				alu_req.a  = limit_q;
				alu_req.b  = ts_q;
			end
			S_WST: begin
				alu_req.op = OP_SUB_SAT;
				alu_req.a  = ts_q;
				alu_req.b  = TS_BITS'(cfg.win_len);
			end
			S_CHK: begin
				alu_req.op = OP_LT;
				alu_req.a  = q_rdata.ts;
				alu_req.b  = ws_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		q_ctrl.push = (state_q == S_PUSH);
		q_ctrl.rd   = (state_q == S_RD) && !q_empty;
		q_ctrl.pop  = (state_q == S_CHK) && alu_rsp.lt;
		q_sel       = (state_q == S_OFFS || state_q == S_PUSH) ? CIDX_W'(cam_q) : c_q;
		q_wdata.ts  = ts_q;
		q_wdata.id  = id_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ws_q    <= '0;
			seq_q   <= '0;
			c_q     <= '0;
			have_q  <= '0;
			ovld_q  <= 1'b0;
		end else begin
			if (load)
				ovld_q <= 1'b1;
			else if (!out_stall)
				ovld_q <= 1'b0;

			unique case (state_q) inside
				S_IDLE: begin
					if (in_valid && cam_ok)
						state_q <= S_OFFS;
				end
				S_OFFS: state_q <= S_PUSH;
				S_PUSH: state_q <= S_CMP;
				S_CMP: begin
					state_q <= alu_rsp.lt ? S_WST : S_IDLE;
				end
				S_WST: begin
					ws_q    <= alu_rsp.res;
					seq_q   <= seq_q + 32'd1;
					have_q  <= '0;
					c_q     <= '0;
					state_q <= S_RD;
				end
				S_RD, S_CHK: begin
					if (state_q == S_RD && !q_empty) begin
						state_q <= S_CHK;
					end else if (state_q == S_CHK && alu_rsp.lt) begin
						have_q[c_q] <= 1'b1;
						state_q     <= S_RD;
					end else if (c_last) begin
						// camera done; emit only if some camera kept a tag
						c_q     <= '0;
						state_q <= (|have_q) ? S_EMIT : S_IDLE;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_EMIT: begin
					if (load) begin
						if (c_last)
							state_q <= S_IDLE;
						else
							c_q <= c_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cam_q <= in_req.in_camera;
			ts_q  <= in_req.in_timestamp;
			id_q  <= in_req.in_frame_id;
		end
		if (state_q == S_OFFS)
			ts_q <= alu_rsp.res;
		if (state_q == S_PUSH)
			limit_q <= alu_rsp.res;
		if (state_q == S_CHK && alu_rsp.lt)
			kept_q[c_q] <= q_rdata;
		if (load) begin
			orsp_q.out_camera    <= 2'(c_q);
			orsp_q.out_valid     <= have_q[c_q];
			orsp_q.out_frame_id  <= have_q[c_q] ? kept_c.id : '0;
			orsp_q.out_timestamp <= have_q[c_q] ? kept_c.ts : '0;
			orsp_q.out_sequence  <= seq_q;
			orsp_q.out_last      <= c_last;
		end
	end

`ifndef NO_ASSERTIONS
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != $past(seq_q)) |-> (seq_q == $past(seq_q) + 32'd1))
		else $error("sequence count moved by other than one");
	a_ws_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(ws_q != $past(ws_q)) |-> (ws_q > $past(ws_q)))
		else $error("window start moved backward");
	a_set_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && $past(state_q) == S_EMIT) |-> (ovld_q && orsp_q.out_last))
		else $error("frameset closed without a last entry");
	a_pop_older: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK && alu_rsp.lt) |-> (q_rdata.ts < ws_q))
		else $error("popped tag not older than window start");
`endif

endmodule

/* rtl/core/multi_camera_frame_window_aligner.sv */
`timescale 1ns / 1ps
// multi_camera_frame_window_aligner: top level with the register port, the
// sequencer, the shared timestamp unit and the per-camera tag queues.
// Depends on mcfwa_pkg, mcfwa_alu, mcfwa_queue, mcfwa_ctrl.
//
//  port group   direction  handshake                    payload
//  ----------   ---------  ---------------------------  ---------------------
//  in           request    in_valid / in_stall          in_req  (in_req_t)
//  out          result     out_valid / out_stall        out_rsp (out_rsp_t)
//  apb          config     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A request for a camera outside the active count is consumed without effect.
// Otherwise it is accepted, offset, pushed with the limit and compared; a window move
// adds a window-start step, then per active camera a read and check per tag popped
// and a read if its queue is empty or a read and check if its head stays; then results.
// Reset empties the queues and loads register defaults; no clearing pass.
// out_stall holds the output register and the sequencer while results remain to load.
module multi_camera_frame_window_aligner #(
	parameter int NUM_CAMERAS = mcfwa_pkg::DEF_NUM_CAMERAS,
	parameter int QUEUE_DEPTH = mcfwa_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mcfwa_pkg::CFG_AW-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  mcfwa_pkg::in_req_t            in_req,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mcfwa_pkg::out_rsp_t           out_rsp
);
	import mcfwa_pkg::*;

	localparam int CIDX_W = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;

	logic [31:0]                  win_len_q;
	logic [2:0]                   cams_q;
	logic [NUM_OFFSETS-1:0][31:0] offset_q;
	cfg_t                         cfg;
	logic                         wr_en;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	q_ctrl_t           q_ctrl;
	logic [CIDX_W-1:0] q_sel;
	tag_t              q_wdata;
	tag_t              q_rdata;
	logic              q_empty;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= '0;
			cams_q    <= 3'd4;
			offset_q  <= '0;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_WIN_LEN:        win_len_q   <= pwdata;
				REG_CAMERAS_IN_USE: cams_q      <= pwdata[2:0];
				REG_OFFSET_CAM0:    offset_q[0] <= pwdata;
				REG_OFFSET_CAM1:    offset_q[1] <= pwdata;
				REG_OFFSET_CAM2:    offset_q[2] <= pwdata;
				REG_OFFSET_CAM3:    offset_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_WIN_LEN:        prdata = win_len_q;
			REG_CAMERAS_IN_USE: prdata = 32'(cams_q);
			REG_OFFSET_CAM0:    prdata = offset_q[0];
			REG_OFFSET_CAM1:    prdata = offset_q[1];
			REG_OFFSET_CAM2:    prdata = offset_q[2];
			REG_OFFSET_CAM3:    prdata = offset_q[3];
			default:            prdata = '0;
		endcase
	end

	always_comb begin
		cfg.win_len        = win_len_q;
		cfg.cameras_in_use = cams_q;
		cfg.offset         = offset_q;
	end

	mcfwa_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	mcfwa_queue #(
		.NUM_CAMERAS (NUM_CAMERAS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (q_ctrl),
		.sel    (q_sel),
		.wdata  (q_wdata),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	mcfwa_ctrl #(
		.NUM_CAMERAS (NUM_CAMERAS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rsp   (out_rsp),
		.alu_req   (alu_req),
		.alu_rsp   (alu_rsp),
		.q_ctrl    (q_ctrl),
		.q_sel     (q_sel),
		.q_wdata   (q_wdata),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata)
	);

endmodule

/* test/multi_camera_frame_window_aligner_tb.sv */
`timescale 1ns / 1ps
// multi_camera_frame_window_aligner_tb: self-checking bench for the frame window aligner.
// It keeps its own copy of the tag queues, the window and the registers, and predicts each frameset.
// Depends on mcfwa_pkg and multi_camera_frame_window_aligner.
module multi_camera_frame_window_aligner_tb;
	import mcfwa_pkg::*;

	localparam int     CAMS        = DEF_NUM_CAMERAS;
	localparam int     DEPTH       = DEF_QUEUE_DEPTH;
	localparam longint STAMP_MAX   = (longint'(1) <<< (TS_BITS - 1)) - 1;
	localparam longint STAMP_MIN   = -STAMP_MAX - 1;
	localparam int     SETTLE      = 200;
	localparam int     QUIET_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	in_req_t     in_req;
	logic        out_valid;
	logic        out_stall;
	out_rsp_t    out_rsp;

	// predicted block state
	longint             tag_stamp [CAMS][DEPTH];
	logic [15:0]        tag_frame [CAMS][DEPTH];
	int                 tag_head  [CAMS];
	int                 tag_count [CAMS];
	longint             win_start;
	logic [31:0]        win_seq;
	logic [31:0]        cfg_window;
	logic [2:0]         cfg_cameras;
	logic signed [31:0] cfg_offset [CAMS];

	out_rsp_t frameset_q[$];
	out_rsp_t want_rsp;
	int       errors       = 0;
	int       tags_used    = 0;
	int       snd_idle_pct = 18;
	int       rcv_idle_pct = 58;

	multi_camera_frame_window_aligner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rsp   (out_rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Returns -1 for an ignored tag, else the number of results it causes.
	function automatic int align_tag(in_req_t t);
		int          arity;
		int          cam;
		int          slot;
		longint      stamp;
		longint      off;
		longint      limit;
		longint      kept_stamp;
		logic [15:0] kept_frame;
		bit          have;
		bit          popped_any;
		out_rsp_t    entry [CAMS];
		arity = (cfg_cameras > CAMS) ? CAMS : cfg_cameras;
		cam = t.in_camera;
		if (cam >= arity)
			return -1;
		stamp = {{(64-TS_BITS){t.in_timestamp[TS_BITS-1]}}, t.in_timestamp};
		off = {{32{cfg_offset[cam][31]}}, cfg_offset[cam]};
		if (off > 0 && stamp < STAMP_MIN + off)
			stamp = STAMP_MIN;
		else if (off < 0 && stamp > STAMP_MAX + off)
			stamp = STAMP_MAX;
		else
			stamp = stamp - off;

		// full queue loses its oldest tag
		if (tag_count[cam] >= DEPTH) begin
			tag_head[cam] = (tag_head[cam] + 1) % DEPTH;
			tag_count[cam] = DEPTH - 1;
		end
		slot = (tag_head[cam] + tag_count[cam]) % DEPTH;
		tag_stamp[cam][slot] = stamp;
		tag_frame[cam][slot] = t.in_frame_id;
		tag_count[cam]++;

		if (win_start > STAMP_MAX - longint'(cfg_window))
			limit = STAMP_MAX;
		else
			limit = win_start + longint'(cfg_window);
		if (stamp <= limit)
			return 0;

		win_start = stamp - longint'(cfg_window);
		win_seq = win_seq + 32'd1;
		popped_any = 1'b0;
		for (int c = 0; c < arity; c++) begin
			have = 1'b0;
			kept_stamp = 0;
			kept_frame = '0;
			while (tag_count[c] > 0 && tag_stamp[c][tag_head[c]] < win_start) begin
				kept_stamp = tag_stamp[c][tag_head[c]];
				kept_frame = tag_frame[c][tag_head[c]];
				have = 1'b1;
				tag_head[c] = (tag_head[c] + 1) % DEPTH;
				tag_count[c]--;
			end
			popped_any |= have;
			entry[c].out_camera    = 2'(c);
			entry[c].out_valid     = have;
			entry[c].out_frame_id  = kept_frame;
			entry[c].out_timestamp = kept_stamp[TS_BITS-1:0];
			entry[c].out_sequence  = win_seq;
			entry[c].out_last      = (c == arity - 1);
		end
		if (!popped_any)
			return 0;
		for (int c = 0; c < arity; c++)
			frameset_q.insert(frameset_q.size(), entry[c]);
		return arity;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_WIN_LEN:        cfg_window = value;
			REG_CAMERAS_IN_USE: cfg_cameras = value[2:0];
			REG_OFFSET_CAM0:    cfg_offset[0] = value;
			REG_OFFSET_CAM1:    cfg_offset[1] = value;
			REG_OFFSET_CAM2:    cfg_offset[2] = value;
			REG_OFFSET_CAM3:    cfg_offset[3] = value;
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Sends one tag; called and returns at a falling edge, leaves valid high.
	task automatic send_tag(logic [1:0] cam, longint raw, logic [15:0] frame);
		in_req_t t;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		t.in_camera    = cam;
		t.in_timestamp = raw[TS_BITS-1:0];
		t.in_frame_id  = frame;
		in_req = t;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		if (align_tag(t) >= 0)
			tags_used++;
		@(negedge clk);
	endtask

	// target is the stamp wanted after the camera offset is taken off
	task automatic send_adj(logic [1:0] cam, longint target, logic [15:0] frame);
		send_tag(cam, target + longint'(cfg_offset[cam]), frame);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (frameset_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic test_reset_defaults();
		send_tag(2'd0, 0, 16'h0000);
		send_tag(2'd1, -5, 16'hFFFF);
		send_tag(2'd2, STAMP_MIN, 16'h1234);
		// moves the window; camera 3 has nothing, so its entry is invalid
		send_tag(2'd0, 10, 16'h0001);
	endtask

	task automatic test_camera_count();
		wait_idle();
		write_reg(REG_CAMERAS_IN_USE, 32'd2);
		write_reg(REG_WIN_LEN, 32'd20);
		send_adj(2'd3, win_start + 100, 16'h00C3);
		send_adj(2'd1, win_start + 5, 16'h0051);
		send_adj(2'd0, win_start + 50, 16'h0050);
		wait_idle();
		write_reg(REG_CAMERAS_IN_USE, 32'd7);
		send_adj(2'd3, win_start + 1, 16'h0073);
		wait_idle();
		write_reg(REG_CAMERAS_IN_USE, 32'd0);
		send_adj(2'd0, win_start + 1000, 16'h0000);
	endtask

	task automatic test_offset_saturation();
		wait_idle();
		write_reg(REG_CAMERAS_IN_USE, 32'd4);
		write_reg(REG_WIN_LEN, 32'hFFFF_0000);
		write_reg(REG_OFFSET_CAM0, 32'h0000_0001);
		write_reg(REG_OFFSET_CAM1, 32'h8000_0000);
		write_reg(REG_OFFSET_CAM2, 32'h7FFF_FFFF);
		write_reg(REG_OFFSET_CAM3, 32'hFFFF_FFFF);
		send_tag(2'd0, STAMP_MIN, 16'hA000);
		send_tag(2'd2, 1000, 16'hA002);
		send_tag(2'd3, win_start + 3, 16'hA003);
		// clips to the top of the range and leaves the window just under it
		send_tag(2'd1, STAMP_MAX, 16'hFFFF);
		wait_idle();
		// start plus size now overflows, so the limit clips
		write_reg(REG_WIN_LEN, 32'hFFFF_FFFF);
		send_adj(2'd0, win_start + 1, 16'hA100);
	endtask

	task automatic test_queue_overflow();
		wait_idle();
		write_reg(REG_WIN_LEN, 32'd8);
		// camera 1 holds the top-of-range tag; a full queue pushes it out
		for (int i = 0; i < DEPTH; i++)
			send_adj(2'd1, win_start + 1 + (i % 8), 16'(16'hB000 + i));
		send_adj(2'd2, win_start + 100, 16'hBEEF);
	endtask

	task automatic test_random_traffic(int n_tags, int move_pct);
		longint      target;
		logic [47:0] noise;
		logic [1:0]  cam;
		int          arity;
		int          first;
		wait_idle();
		case ($urandom_range(3))
			0: write_reg(REG_WIN_LEN, 32'd0);
			1: write_reg(REG_WIN_LEN, $urandom_range(1, 64));
			2: write_reg(REG_WIN_LEN, $urandom_range(65, 4095));
			default: write_reg(REG_WIN_LEN, 32'd1);
		endcase
		write_reg(REG_CAMERAS_IN_USE, $urandom_range(1, 7));
		write_reg(REG_OFFSET_CAM0, $urandom);
		write_reg(REG_OFFSET_CAM1, $urandom);
		write_reg(REG_OFFSET_CAM2, $urandom);
		write_reg(REG_OFFSET_CAM3, $urandom);
		arity = (cfg_cameras > CAMS) ? CAMS : cfg_cameras;
		first = tags_used;
		while (tags_used - first < n_tags) begin
			if ($urandom_range(99) < 20) begin
				noise = {16'($urandom), 32'($urandom)};
				// stray stamps near the top are flipped negative so the window keeps room
				if (!noise[47] && &noise[46:33])
					noise[47] = 1'b1;
				send_tag(2'($urandom_range(3)), {{16{noise[47]}}, noise}, 16'($urandom));
			end else begin
				if ($urandom_range(99) < 5)
					cam = 2'($urandom_range(3));
				else
					cam = 2'($urandom_range(arity - 1));
				if ($urandom_range(99) < move_pct)
					target = win_start + longint'(cfg_window) + 1
						+ longint'($urandom_range(2 * cfg_window + 40));
				else
					target = win_start + longint'($urandom_range(cfg_window));
				send_adj(cam, target, 16'($urandom));
			end
		end
	endtask

	task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			errors++;
		end
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(99) < rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (frameset_q.size() == 0) begin
				$display("%0t: result with none expected, actual %p", $time, out_rsp);
				errors++;
			end else begin
				want_rsp = frameset_q[0];
				frameset_q.delete(0);
				check_field("out_camera", want_rsp.out_camera, out_rsp.out_camera);
				check_field("out_valid", want_rsp.out_valid, out_rsp.out_valid);
				check_field("out_frame_id", want_rsp.out_frame_id, out_rsp.out_frame_id);
				check_field("out_timestamp", want_rsp.out_timestamp, out_rsp.out_timestamp);
				check_field("out_sequence", want_rsp.out_sequence, out_rsp.out_sequence);
				check_field("out_last", want_rsp.out_last, out_rsp.out_last);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
					|| (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		win_start = 0;
		win_seq = '0;
		cfg_window = '0;
		cfg_cameras = 3'd4;
		for (int c = 0; c < CAMS; c++) begin
			tag_head[c] = 0;
			tag_count[c] = 0;
			cfg_offset[c] = '0;
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_camera_count();
		test_offset_saturation();
		test_queue_overflow();
		test_random_traffic(70, 8);
		test_random_traffic(70, 40);
		snd_idle_pct = 58;
		rcv_idle_pct = 18;
		test_random_traffic(70, 15);
		test_random_traffic(70, 60);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random_traffic(70, 5);
		test_random_traffic(70, 30);
		wait_idle();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
